// ===== hdl/inverse_affine_pixel_remap_defines.svh =====
// assertion macros for the inverse affine pixel remap checker
// no dependencies; taken in by the checker file through `include
`ifndef INVERSE_AFFINE_PIXEL_REMAP_DEFINES_SVH
`define INVERSE_AFFINE_PIXEL_REMAP_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define IAPR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("iapr check failed");

// implication with a fixed delay in cycles
`define IAPR_ASSERT_DELAY(label, clk, rst_n, n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
		else $error("iapr check failed");

`endif

// ===== hdl/iapr_pkg.sv =====
// shared types and constants of the inverse affine pixel remap
// no dependencies; used by iapr_map, the top level and the checker
`default_nettype none

package iapr_pkg;

	localparam int unsigned COORD_W    = 8;
	localparam int unsigned PIX_W      = 32;
	localparam int unsigned SIZE_W     = 9;
	localparam int unsigned COEF_W     = 24;
	localparam int unsigned SHIFT_W    = 13;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 24;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_READ  = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 3'd0,
		REG_FRAME_HEIGHT = 3'd1,
		REG_COEF_A       = 3'd2,
		REG_COEF_B       = 3'd3,
		REG_COEF_C       = 3'd4,
		REG_COEF_D       = 3'd5,
		REG_SHIFT_X      = 3'd6,
		REG_SHIFT_Y      = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [SIZE_W-1:0]  frame_width;
		logic [SIZE_W-1:0]  frame_height;
		logic [COEF_W-1:0]  coef_a;
		logic [COEF_W-1:0]  coef_b;
		logic [COEF_W-1:0]  coef_c;
		logic [COEF_W-1:0]  coef_d;
		logic [SHIFT_W-1:0] shift_x;
		logic [SHIFT_W-1:0] shift_y;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		frame_width:  SIZE_W'(256),
		frame_height: SIZE_W'(256),
		coef_a:       COEF_W'(256),
		coef_b:       '0,
		coef_c:       COEF_W'(256),
		coef_d:       '0,
		shift_x:      '0,
		shift_y:      '0
	};

	// per-request control travelling alongside the address
	typedef struct packed {
		logic vld;
		logic rd;
		logic hit;
	} ctl_t;

endpackage

`default_nettype wire

// ===== hdl/iapr_ram.sv =====
// generic single-port ram with registered read data
// no dependencies
`default_nettype none

module iapr_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 65536
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

`default_nettype wire

// ===== hdl/iapr_map.sv =====
// coordinate mapping pipeline: offsets and products, then sums, floor and bounds
// depends on iapr_pkg
`default_nettype none

module iapr_map #(
	parameter int unsigned MAX_WIDTH  = 256,
	parameter int unsigned MAX_HEIGHT = 256,
	parameter int unsigned FRAC_BITS  = 8
) (
	input  wire logic                                          clk,
	input  wire logic                                          arst_n,
	input  wire logic                                          vld_s1,
	input  wire logic                                          cmd_s1,
	input  wire logic [iapr_pkg::COORD_W-1:0]                  col_s1,
	input  wire logic [iapr_pkg::COORD_W-1:0]                  row_s1,
	input  wire logic [iapr_pkg::PIX_W-1:0]                    pix_s1,
	input  wire iapr_pkg::cfg_t                                cfg,
	output iapr_pkg::ctl_t                                     ctl_s3,
	output logic      [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]       addr_s3,
	output logic      [iapr_pkg::PIX_W-1:0]                    pix_s3
);

	localparam int unsigned ADDR_W = $clog2(MAX_WIDTH * MAX_HEIGHT);
	localparam int unsigned SZW_W  = $clog2(MAX_WIDTH + 1);
	localparam int unsigned SZH_W  = $clog2(MAX_HEIGHT + 1);
	localparam int unsigned SZ_W   = (SZW_W > SZH_W) ? SZW_W : SZH_W;
	localparam int unsigned DX_W   =
		((SZ_W > iapr_pkg::SHIFT_W) ? SZ_W : iapr_pkg::SHIFT_W) + 2;
	localparam int unsigned PROD_W = DX_W + iapr_pkg::COEF_W;
	localparam int unsigned SUM_W  =
		((PROD_W > SZ_W + FRAC_BITS) ? PROD_W : SZ_W + FRAC_BITS) + 2;
	localparam int unsigned XW     = $clog2(MAX_WIDTH);
	localparam int unsigned YW     = $clog2(MAX_HEIGHT);

	// stage 1: clamp frame size, offsets, products, write address and write bounds check
	logic        [SZ_W-1:0]   w_c;
	logic        [SZ_W-1:0]   h_c;
	logic        [SZ_W-1:0]   cx_c;
	logic        [SZ_W-1:0]   cy_c;
	logic signed [DX_W-1:0]   dx_c;
	logic signed [DX_W-1:0]   dy_c;
	logic signed [iapr_pkg::COEF_W-1:0] coef_a_c;
	logic signed [iapr_pkg::COEF_W-1:0] coef_b_c;
	logic signed [iapr_pkg::COEF_W-1:0] coef_c_c;
	logic signed [iapr_pkg::COEF_W-1:0] coef_d_c;
	logic signed [PROD_W-1:0] pa_c;
	logic signed [PROD_W-1:0] pb_c;
	logic signed [PROD_W-1:0] pc_c;
	logic signed [PROD_W-1:0] pd_c;
	logic                     wok_c;
	logic        [ADDR_W-1:0] waddr_c;

	always_comb begin
		if (cfg.frame_width == '0) begin
			w_c = SZ_W'(1);
		end else if (32'(cfg.frame_width) > 32'(MAX_WIDTH)) begin
			w_c = SZ_W'(MAX_WIDTH);
		end else begin
			w_c = SZ_W'(cfg.frame_width);
		end
		if (cfg.frame_height == '0) begin
			h_c = SZ_W'(1);
		end else if (32'(cfg.frame_height) > 32'(MAX_HEIGHT)) begin
			h_c = SZ_W'(MAX_HEIGHT);
		end else begin
			h_c = SZ_W'(cfg.frame_height);
		end
		cx_c = w_c >> 1;
		cy_c = h_c >> 1;
		dx_c = signed'(DX_W'(col_s1)) - signed'(DX_W'(cx_c))
			- DX_W'($signed(cfg.shift_x));
		dy_c = signed'(DX_W'(row_s1)) - signed'(DX_W'(cy_c))
			- DX_W'($signed(cfg.shift_y));
		coef_a_c = $signed(cfg.coef_a);
		coef_b_c = $signed(cfg.coef_b);
		coef_c_c = $signed(cfg.coef_c);
		coef_d_c = $signed(cfg.coef_d);
		pa_c = dx_c * coef_a_c;
		pb_c = dy_c * coef_b_c;
		pc_c = dy_c * coef_c_c;
		pd_c = dx_c * coef_d_c;
		wok_c = (32'(col_s1) < 32'(MAX_WIDTH)) && (32'(row_s1) < 32'(MAX_HEIGHT));
		waddr_c = ADDR_W'(row_s1) * ADDR_W'(MAX_WIDTH) + ADDR_W'(col_s1);
	end

	logic                     vld_s2;
	logic                     rd_s2;
	logic                     wok_s2;
	logic        [ADDR_W-1:0] waddr_s2;
	logic [iapr_pkg::PIX_W-1:0] pix_s2;
	logic        [SZ_W-1:0]   w_s2;
	logic        [SZ_W-1:0]   h_s2;
	logic        [SZ_W-1:0]   cx_s2;
	logic        [SZ_W-1:0]   cy_s2;
	logic signed [PROD_W-1:0] pa_s2;
	logic signed [PROD_W-1:0] pb_s2;
	logic signed [PROD_W-1:0] pc_s2;
	logic signed [PROD_W-1:0] pd_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		rd_s2    <= (cmd_s1 == iapr_pkg::CMD_READ);
		wok_s2   <= wok_c;
		waddr_s2 <= waddr_c;
		pix_s2   <= pix_s1;
		w_s2     <= w_c;
		h_s2     <= h_c;
		cx_s2    <= cx_c;
		cy_s2    <= cy_c;
		pa_s2    <= pa_c;
		pb_s2    <= pb_c;
		pc_s2    <= pc_c;
		pd_s2    <= pd_c;
	end

	// stage 2: sums, floor by arithmetic shift, bounds check, read address
	logic signed [SUM_W-1:0]  sx_c;
	logic signed [SUM_W-1:0]  sy_c;
	logic signed [SUM_W-1:0]  xp_c;
	logic signed [SUM_W-1:0]  yp_c;
	logic                     inside_c;
	logic        [ADDR_W-1:0] raddr_c;

	always_comb begin
		sx_c = SUM_W'(pa_s2) + SUM_W'(pb_s2) + (signed'(SUM_W'(cx_s2)) <<< FRAC_BITS);
		sy_c = SUM_W'(pc_s2) + SUM_W'(pd_s2) + (signed'(SUM_W'(cy_s2)) <<< FRAC_BITS);
		xp_c = sx_c >>> FRAC_BITS;
		yp_c = sy_c >>> FRAC_BITS;
		inside_c = !xp_c[SUM_W-1] && (xp_c < signed'(SUM_W'(w_s2)))
			&& !yp_c[SUM_W-1] && (yp_c < signed'(SUM_W'(h_s2)));
		raddr_c = ADDR_W'(yp_c[YW-1:0]) * ADDR_W'(MAX_WIDTH) + ADDR_W'(xp_c[XW-1:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
		end else begin
			ctl_s3.vld <= vld_s2;
			ctl_s3.rd  <= rd_s2;
			ctl_s3.hit <= rd_s2 ? inside_c : wok_s2;
		end
	end

	always_ff @(posedge clk) begin
		addr_s3 <= rd_s2 ? raddr_c : waddr_s2;
		pix_s3  <= pix_s2;
	end

endmodule

`default_nettype wire

// ===== hdl/inverse_affine_pixel_remap.sv =====
// top level of the inverse affine pixel remap: config registers, input stage, frame ram
// depends on iapr_pkg, iapr_map and iapr_ram
`default_nettype none

// Pixel writes and remapped reads share one four-stage pipeline and one
// request may be started every cycle; busy never rises. A read gives its
// result on done after the input register, the offset and multiply stage,
// the sum and bounds stage, then the registered read of the frame ram,
// whose single port takes one write or one read per cycle. A write gives
// no result. Results are shown for one cycle only and cannot be held off
// by the receiver. The frame ram is not cleared after reset, so a pixel
// must be written before any read maps onto it. Configuration writes are
// always taken (cfg_ready is high) and apply to requests started later.
module inverse_affine_pixel_remap #(
	parameter int unsigned MAX_WIDTH  = 256,
	parameter int unsigned MAX_HEIGHT = 256,
	parameter int unsigned FRAC_BITS  = 8
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic                                cmd,
	input  wire logic [iapr_pkg::COORD_W-1:0]        col,
	input  wire logic [iapr_pkg::COORD_W-1:0]        row,
	input  wire logic [iapr_pkg::PIX_W-1:0]          pixel_in,
	output logic                                     done,
	output logic      [iapr_pkg::PIX_W-1:0]          pixel_out,
	output logic                                     inside_res,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [iapr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [iapr_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int unsigned ADDR_W = $clog2(MAX_WIDTH * MAX_HEIGHT);
	localparam int unsigned DEPTH  = MAX_WIDTH * MAX_HEIGHT;

	iapr_pkg::cfg_t cfg_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= iapr_pkg::CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (iapr_pkg::cfg_reg_t'(cfg_index))
				iapr_pkg::REG_FRAME_WIDTH: begin
					cfg_q.frame_width <= cfg_data[iapr_pkg::SIZE_W-1:0];
				end
				iapr_pkg::REG_FRAME_HEIGHT: begin
					cfg_q.frame_height <= cfg_data[iapr_pkg::SIZE_W-1:0];
				end
				iapr_pkg::REG_COEF_A: begin
					cfg_q.coef_a <= cfg_data[iapr_pkg::COEF_W-1:0];
				end
				iapr_pkg::REG_COEF_B: begin
					cfg_q.coef_b <= cfg_data[iapr_pkg::COEF_W-1:0];
				end
				iapr_pkg::REG_COEF_C: begin
					cfg_q.coef_c <= cfg_data[iapr_pkg::COEF_W-1:0];
				end
				iapr_pkg::REG_COEF_D: begin
					cfg_q.coef_d <= cfg_data[iapr_pkg::COEF_W-1:0];
				end
				iapr_pkg::REG_SHIFT_X: begin
					cfg_q.shift_x <= cfg_data[iapr_pkg::SHIFT_W-1:0];
				end
				iapr_pkg::REG_SHIFT_Y: begin
					cfg_q.shift_y <= cfg_data[iapr_pkg::SHIFT_W-1:0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	// input register
	logic                          vld_s1;
	logic                          cmd_s1;
	logic [iapr_pkg::COORD_W-1:0]  col_s1;
	logic [iapr_pkg::COORD_W-1:0]  row_s1;
	logic [iapr_pkg::PIX_W-1:0]    pix_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s1 <= cmd;
		col_s1 <= col;
		row_s1 <= row;
		pix_s1 <= pixel_in;
	end

	iapr_pkg::ctl_t             ctl_s3;
	logic [ADDR_W-1:0]          addr_s3;
	logic [iapr_pkg::PIX_W-1:0] pix_s3;

	iapr_map #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.FRAC_BITS  (FRAC_BITS)
	) u_map (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_s1  (vld_s1),
		.cmd_s1  (cmd_s1),
		.col_s1  (col_s1),
		.row_s1  (row_s1),
		.pix_s1  (pix_s1),
		.cfg     (cfg_q),
		.ctl_s3  (ctl_s3),
		.addr_s3 (addr_s3),
		.pix_s3  (pix_s3)
	);

	// writes outside the store are dropped
	logic                       ram_we;
	logic [iapr_pkg::PIX_W-1:0] ram_rdata;

	assign ram_we = ctl_s3.vld && !ctl_s3.rd && ctl_s3.hit;

	iapr_ram #(
		.WIDTH (iapr_pkg::PIX_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (addr_s3),
		.wdata (pix_s3),
		.rdata (ram_rdata)
	);

	iapr_pkg::ctl_t ctl_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s4 <= '0;
		end else begin
			ctl_s4 <= ctl_s3;
		end
	end

	assign done       = ctl_s4.vld && ctl_s4.rd;
	assign inside_res = ctl_s4.rd && ctl_s4.hit;
	assign pixel_out  = inside_res ? ram_rdata : '0;

endmodule

`default_nettype wire

// ===== hdl/iapr_chk.sv =====
// port-level checker for the inverse affine pixel remap, bound to the top level
// depends on inverse_affine_pixel_remap_defines.svh and iapr_pkg
`default_nettype none

`include "inverse_affine_pixel_remap_defines.svh"

module iapr_chk (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       start,
	input wire logic                       busy,
	input wire logic                       cmd,
	input wire logic                       done,
	input wire logic [iapr_pkg::PIX_W-1:0] pixel_out,
	input wire logic                       inside_res
);

	logic rd_req;

	assign rd_req = start && !busy && (cmd == iapr_pkg::CMD_READ);

	// every read request is answered on done
	`IAPR_ASSERT_DELAY(a_read_latency, clk, arst_n, 4, rd_req, done)
	// no result without an earlier read request
	`IAPR_ASSERT_NOW(a_done_origin, clk, arst_n, done, $past(rd_req, 4))
	// a point outside the frame gives transparent black
	`IAPR_ASSERT_NOW(a_outside_black, clk, arst_n, done && !inside_res, pixel_out == '0)

endmodule

bind inverse_affine_pixel_remap iapr_chk u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.cmd        (cmd),
	.done       (done),
	.pixel_out  (pixel_out),
	.inside_res (inside_res)
);

`default_nettype wire
